// ===== hdl/swp_pkg.sv =====
`default_nettype none
package swp_pkg;

    localparam int SAMPLE_BITS_W = 7;
    localparam int OUT_WORD_W    = 64;
    localparam int LINE_REG_W    = 16;
    localparam int OUT_DEPTH     = 4;
    localparam int PTR_W         = $clog2(OUT_DEPTH);
    localparam int CNT_W         = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] REG_SAMPLE_BITS      = 2'd0;
    localparam logic [1:0] REG_WORD_SIZE_CODE   = 2'd1;
    localparam logic [1:0] REG_FILL_METHOD      = 2'd2;
    localparam logic [1:0] REG_SAMPLES_PER_LINE = 2'd3;

    localparam logic [1:0] WORD_CODE_16 = 2'd0;
    localparam logic [1:0] WORD_CODE_32 = 2'd1;

    localparam logic FILL_PAD_LOW  = 1'b0;
    localparam logic FILL_PAD_HIGH = 1'b1;

    typedef struct packed {
        logic [OUT_WORD_W-1:0] word;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  item_a;
        t_out_item  item_b;
    } t_push_req;

    function automatic logic [SAMPLE_BITS_W-1:0] word_bits(input logic [1:0] code);
        logic [SAMPLE_BITS_W-1:0] bits;
        case (code)
            WORD_CODE_16: bits = SAMPLE_BITS_W'(16);
            WORD_CODE_32: bits = SAMPLE_BITS_W'(32);
            default:      bits = SAMPLE_BITS_W'(64);
        endcase
        return bits;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sample_word_packer_unit.sv =====
// Sample word packer: packs image samples MSB first into 16/32/64-bit words.
// Input channel: i_in_valid / o_in_stall with i_sample_value, i_end_of_frame.
//   A transfer happens on a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_packed_word, o_last_word.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12
//   (sample_bits, word_size_code, fill_method, samples_per_line). Write
//   only while idle; writing word_size_code drops a partly filled word.
// Flow: a sample is packed while it sits in the input register, once the
//   output queue has room for two words; its words enter the output queue
//   at the end of that cycle and are registered there before they are
//   offered on the output port.
// Throughput: one sample per cycle while each sample yields at most one word
//   and the receiver does not stall; a frame-end sample that also flushes the
//   prior word yields two for the single-word port behind a 4-entry queue.
// Stall: when the receiver stalls, words wait in the queue; the packer stops
//   once the queue has room for fewer than two words, and the input stalls.
// Reset: synchronous, clears the queue, input register, accumulator and line
//   counter and loads the default configuration.
`default_nettype none
module sample_word_packer_unit #(
    parameter int MAX_WORD_BITS   = 64,
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_sample_value,
    input  wire logic        i_end_of_frame,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_packed_word,
    output logic             o_last_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import swp_pkg::*;

    localparam int FREE_W = $clog2(MAX_WORD_BITS + 1);
    localparam int CMP_W  = (LINE_COUNT_BITS > LINE_REG_W) ? LINE_COUNT_BITS : LINE_REG_W;
    localparam logic [MAX_WORD_BITS-1:0] ALL_ONES = '1;

    logic [SAMPLE_BITS_W-1:0]   r_sample_bits;
    logic [1:0]                 r_word_code;
    logic                       r_fill;
    logic [LINE_REG_W-1:0]      r_spl;
    logic [MAX_WORD_BITS-1:0]   r_acc;
    logic [FREE_W-1:0]          r_free;
    logic [LINE_COUNT_BITS-1:0] r_line;
    logic                       r_in_valid;
    logic [63:0]                r_sample;
    logic                       r_eof;

    logic                       cfg_wr;
    logic                       in_take;
    logic                       proc;
    logic                       room2;
    logic                       out_pop;
    t_push_req                  push;
    t_out_item                  head;
    logic [FREE_W-1:0]          cfg_width;
    logic [FREE_W-1:0]          w;
    logic [SAMPLE_BITS_W-1:0]   b_raw;
    logic [FREE_W-1:0]          b;
    logic [MAX_WORD_BITS-1:0]   wmask;
    logic [MAX_WORD_BITS-1:0]   smask;
    logic [MAX_WORD_BITS-1:0]   acc0;
    logic [FREE_W-1:0]          free0;
    logic                       first;
    logic [MAX_WORD_BITS-1:0]   acc1;
    logic [FREE_W-1:0]          free1;
    logic [MAX_WORD_BITS-1:0]   acc2;
    logic [FREE_W-1:0]          free2;
    logic [MAX_WORD_BITS-1:0]   word1;
    logic [MAX_WORD_BITS-1:0]   word2;
    logic [LINE_COUNT_BITS-1:0] line_inc;
    logic [MAX_WORD_BITS-1:0]   n_acc;
    logic [FREE_W-1:0]          n_free;
    logic [LINE_COUNT_BITS-1:0] n_line;

    function automatic logic [FREE_W-1:0] clamp_width(input logic [1:0] code);
        logic [SAMPLE_BITS_W-1:0] bits;
        bits = word_bits(code);
        if (bits > SAMPLE_BITS_W'(MAX_WORD_BITS)) begin
            bits = SAMPLE_BITS_W'(MAX_WORD_BITS);
        end
        return FREE_W'(bits);
    endfunction

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign cfg_width  = clamp_width(pwdata[1:0]);
    assign proc       = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_pop    = o_out_valid && !i_out_stall;
    assign o_packed_word = head.word;
    assign o_last_word   = head.last;

    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLE_BITS:      prdata = 32'(r_sample_bits);
            REG_WORD_SIZE_CODE:   prdata = 32'(r_word_code);
            REG_FILL_METHOD:      prdata = 32'(r_fill);
            REG_SAMPLES_PER_LINE: prdata = 32'(r_spl);
        endcase
    end

    always_comb begin
        w = clamp_width(r_word_code);
        b_raw = (r_sample_bits == '0) ? SAMPLE_BITS_W'(1) : r_sample_bits;
        if (b_raw > SAMPLE_BITS_W'(w)) begin
            b = w;
        end else begin
            b = FREE_W'(b_raw);
        end
        wmask = ALL_ONES >> (FREE_W'(MAX_WORD_BITS) - w);
        smask = ALL_ONES >> (FREE_W'(MAX_WORD_BITS) - b);

        if (r_free > w) begin
            acc0  = '0;
            free0 = w;
        end else begin
            acc0  = r_acc;
            free0 = r_free;
        end

        first = ((r_line == '0) && (free0 != w)) || (free0 < b);
        word1 = ((r_fill == FILL_PAD_LOW) ? (acc0 << free0) : acc0) & wmask;
        acc1  = first ? '0 : acc0;
        free1 = first ? w : free0;
        acc2  = (acc1 << b) | (r_sample[MAX_WORD_BITS-1:0] & smask);
        free2 = FREE_W'(free1 - b);
        word2 = ((r_fill == FILL_PAD_LOW) ? (acc2 << free2) : acc2) & wmask;

        line_inc = LINE_COUNT_BITS'(r_line + LINE_COUNT_BITS'(1));

        if (r_eof) begin
            n_acc  = '0;
            n_free = w;
            n_line = '0;
        end else begin
            n_acc  = acc2;
            n_free = free2;
            n_line = (CMP_W'(line_inc) == CMP_W'(r_spl)) ? '0 : line_inc;
        end

        push.item_a.word = 64'(first ? word1 : word2);
        push.item_a.last = !first;
        push.item_b.word = 64'(word2);
        push.item_b.last = 1'b1;
        if (!proc) begin
            push.count = 2'd0;
        end else begin
            push.count = 2'(first) + 2'(r_eof);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits <= SAMPLE_BITS_W'(10);
            r_word_code   <= WORD_CODE_32;
            r_fill        <= FILL_PAD_LOW;
            r_spl         <= LINE_REG_W'(6144);
            r_acc         <= '0;
            r_free        <= clamp_width(WORD_CODE_32);
            r_line        <= '0;
            r_in_valid    <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_SAMPLE_BITS:    r_sample_bits <= pwdata[SAMPLE_BITS_W-1:0];
                    REG_WORD_SIZE_CODE: begin
                        r_word_code <= pwdata[1:0];
                        r_acc       <= '0;
                        r_free      <= cfg_width;
                    end
                    REG_FILL_METHOD:      r_fill <= pwdata[0];
                    REG_SAMPLES_PER_LINE: r_spl  <= pwdata[LINE_REG_W-1:0];
                endcase
            end else if (proc) begin
                r_acc  <= n_acc;
                r_free <= n_free;
                r_line <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_sample_value;
            r_eof    <= i_end_of_frame;
        end
    end

    swp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_head  (head),
        .o_valid (o_out_valid),
        .o_room2 (room2)
    );

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= w)
        else $error("free bits beyond word width");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_eof && !cfg_wr) |=> (r_line == '0 && r_acc == '0))
        else $error("frame end left packing state");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && push.count == 2'd0))
        else $error("input stalled while packer moved");

endmodule
`default_nettype wire

// ===== hdl/swp_out_fifo.sv =====
`default_nettype none
module swp_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire swp_pkg::t_push_req i_push,
    input  wire logic               i_pop,
    output swp_pkg::t_out_item      o_head,
    output logic                    o_valid,
    output logic                    o_room2
);
    import swp_pkg::*;

    t_out_item        r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] wr_next;

    assign wr_next = PTR_W'(r_wr + PTR_W'(1));
    assign n_wr    = PTR_W'(r_wr + PTR_W'(i_push.count));
    assign n_count = CNT_W'(r_count + CNT_W'(i_push.count) - CNT_W'(i_pop));
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CNT_W'(OUT_DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (i_pop) begin
                r_rd <= PTR_W'(r_rd + PTR_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.item_a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.item_b;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUT_DEPTH))
        else $error("output queue count beyond depth");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && i_push.count == 2'd0) |=> r_count == CNT_W'($past(r_count) - 1'b1))
        else $error("pop without push did not drop count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (o_room2 || (i_pop && i_push.count == 2'd1)))
        else $error("push into full output queue");

endmodule
`default_nettype wire
